### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Sizes, types and helpers of the grid shortest path search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int TOTW  = 2 * DIMW;
  localparam int LENW  = 13;
  localparam int CFGW  = 7;
  localparam int IDXW  = 8;

  localparam logic [IDXW-1:0] REG_ROW_COUNT = IDXW'(0);
  localparam logic [IDXW-1:0] REG_COL_COUNT = IDXW'(1);

  typedef struct packed {
    logic [RW-1:0]   row;
    logic [CW-1:0]   col;
    logic [LENW-1:0] hops;
  } gsp_qent_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic          blocked;
  } gsp_load_t;

  typedef struct packed {
    logic            valid;
    logic            found;
    logic [LENW-1:0] len;
  } gsp_res_t;

  function automatic logic [DIMW-1:0] clamp_dim(input logic [CFGW-1:0] v, input int maxv);
    logic [DIMW-1:0] r;
    if (v == '0) r = DIMW'(1);
    else if (int'(v) > maxv) r = DIMW'(maxv);
    else r = DIMW'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/grid_shortest_path_bfs.sv
// Loading: one cell word per cycle, accepted back to back while no search runs.
// Search: a start check of the origin cell, then per dequeued cell a queue read,
// nine neighbor reads through the grid RAM port and a drain step, then the result.
// Results sit in an output register; cell loading continues while one waits.
// Reset is synchronous, active low; it clears control state only, with no
// clearing pass: the grid RAM holds what was last loaded or marked visited.
// ----------------------------------------------------------------------------
// grid_shortest_path_bfs
// Eight-connected BFS shortest path over a loaded grid of open/blocked cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grid_shortest_path_bfs import gsp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,   // [0] cell_blocked
  input  wire logic            in_tlast,   // last_cell
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [15:0]          out_tdata,  // [0] found, [13:1] path_length
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [IDXW-1:0] cfg_index,
  input  wire logic [CFGW-1:0] cfg_data
);

  logic [CFGW-1:0] row_count_r, col_count_r;
  logic [AW:0]     load_idx_r, load_idx_nxt;
  logic            out_valid_r;
  logic            out_found_r;
  logic [LENW-1:0] out_len_r;

  logic [DIMW-1:0] rows, cols;
  logic [TOTW-1:0] total;
  logic            busy, in_acc, start;
  gsp_load_t       load;
  gsp_res_t        res;

  assign rows      = clamp_dim(row_count_r, MAX_ROWS);
  assign cols      = clamp_dim(col_count_r, MAX_COLS);
  assign total     = rows * cols;
  assign in_tready = !busy;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && in_tlast;

  always_comb begin
    load.we      = in_acc && (TOTW'(load_idx_r) < total);
    load.addr    = load_idx_r[AW-1:0];
    load.blocked = in_tdata[0];
    load_idx_nxt = load_idx_r;
    if (load.we) load_idx_nxt = load_idx_r + 1'b1;
    if (start) load_idx_nxt = '0;
    if (cfg_valid && ((cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COL_COUNT))) begin
      load_idx_nxt = '0;
    end
  end

  gsp_search u_search (
    .clk(clk), .rst_n(rst_n), .load(load), .start(start), .rows(rows), .cols(cols),
    .out_busy(out_valid_r && !out_tready), .busy(busy), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFGW'(3);
      col_count_r <= CFGW'(3);
      load_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      load_idx_r <= load_idx_nxt;
      if (cfg_valid && (cfg_index == REG_ROW_COUNT)) row_count_r <= cfg_data;
      if (cfg_valid && (cfg_index == REG_COL_COUNT)) col_count_r <= cfg_data;
      if (res.valid) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_found_r <= res.found;
      out_len_r   <= res.len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_found_r};

  // A last cell word starts a search, which holds off further cell words.
  `GSP_ASSERT_NXT(a_start_busy, in_tvalid && in_tready && in_tlast, !in_tready, "search did not start")
  // A found result always carries a nonzero length, and a miss carries zero.
  `GSP_ASSERT_IMP(a_len_found, out_tvalid, out_tdata[0] == (out_tdata[13:1] != '0), "bad length")

endmodule

`default_nettype wire

### hw/rtl/gsp_ram.sv
// ----------------------------------------------------------------------------
// gsp_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_ram #(
  parameter int W = 1,
  parameter int D = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [$clog2(D)-1:0]   wa,
  input  wire logic [W-1:0]           wd,
  input  wire logic [$clog2(D)-1:0]   ra,
  output logic      [W-1:0]           rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

### hw/rtl/gsp_search.sv
// ----------------------------------------------------------------------------
// gsp_search
// Grid store, frontier queue and the BFS sequencer. A visited cell is marked
// by setting its grid bit, so an open bit means open and not yet reached.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_search import gsp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gsp_load_t       load,
  input  wire logic            start,
  input  wire logic [DIMW-1:0] rows,
  input  wire logic [DIMW-1:0] cols,
  input  wire logic            out_busy,
  output logic                 busy,
  output gsp_res_t             res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_SCHK  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_CUR   = 4'd4;
  localparam logic [3:0] S_NB    = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]      state_r, state_nxt;
  logic [AW:0]     head_r, head_nxt, tail_r, tail_nxt;
  gsp_qent_t       cur_r, cur_nxt;
  logic [1:0]      dr_r, dr_nxt, dc_r, dc_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic [RW-1:0]   pend_row_r, pend_row_nxt;
  logic [CW-1:0]   pend_col_r, pend_col_nxt;
  logic [LENW-1:0] len_r, len_nxt;

  logic            g_we, g_wd, g_rd;
  logic [AW-1:0]   g_wa, g_ra;
  logic            q_we;
  gsp_qent_t       q_wd, q_rd;

  logic            row_ok, col_ok;
  logic [RW-1:0]   nr;
  logic [CW-1:0]   nc;
  logic [AW-1:0]   nx;

  gsp_ram #(.W(1), .D(CELLS)) u_grid (
    .clk(clk), .we(g_we), .wa(g_wa), .wd(g_wd), .ra(g_ra), .rd(g_rd)
  );

  gsp_ram #(.W($bits(gsp_qent_t)), .D(CELLS)) u_queue (
    .clk(clk), .we(q_we), .wa(tail_r[AW-1:0]), .wd(q_wd), .ra(head_r[AW-1:0]), .rd(q_rd)
  );

  // Neighbor coordinates and bounds for the current step.
  always_comb begin
    row_ok = !((dr_r == 2'd0) && (cur_r.row == '0)) &&
             !((dr_r == 2'd2) && (DIMW'(cur_r.row) == rows - DIMW'(1)));
    col_ok = !((dc_r == 2'd0) && (cur_r.col == '0)) &&
             !((dc_r == 2'd2) && (DIMW'(cur_r.col) == cols - DIMW'(1)));
    case (dr_r)
      2'd0:    nr = cur_r.row - RW'(1);
      2'd2:    nr = cur_r.row + RW'(1);
      default: nr = cur_r.row;
    endcase
    case (dc_r)
      2'd0:    nc = cur_r.col - CW'(1);
      2'd2:    nc = cur_r.col + CW'(1);
      default: nc = cur_r.col;
    endcase
    nx = AW'(nr) * AW'(cols) + AW'(nc);
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    len_nxt       = len_r;
    pend_v_nxt    = 1'b0;
    pend_addr_nxt = nx;
    pend_row_nxt  = nr;
    pend_col_nxt  = nc;
    g_we          = load.we;
    g_wa          = load.addr;
    g_wd          = load.blocked;
    g_ra          = nx;
    q_we          = 1'b0;
    q_wd          = '{row: pend_row_r, col: pend_col_r, hops: cur_r.hops + LENW'(1)};
    res           = '{valid: 1'b0, found: (len_r != '0), len: len_r};

    // A neighbor read last cycle that found an open cell is marked and queued.
    if (pend_v_r && !g_rd) begin
      g_we     = 1'b1;
      g_wa     = pend_addr_r;
      g_wd     = 1'b1;
      q_we     = 1'b1;
      tail_nxt = tail_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          len_nxt   = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        g_ra      = '0;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (!g_rd) begin
          g_we      = 1'b1;
          g_wa      = '0;
          g_wd      = 1'b1;
          q_we      = 1'b1;
          q_wd      = '{row: '0, col: '0, hops: LENW'(1)};
          tail_nxt  = tail_r + 1'b1;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          state_nxt = S_DONE;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cur_nxt = q_rd;
        dr_nxt  = 2'd0;
        dc_nxt  = 2'd0;
        if ((DIMW'(q_rd.row) == rows - DIMW'(1)) && (DIMW'(q_rd.col) == cols - DIMW'(1)))
        begin
          len_nxt   = q_rd.hops;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        pend_v_nxt = row_ok && col_ok;
        if (dc_r == 2'd2) begin
          dc_nxt = 2'd0;
          if (dr_r == 2'd2) state_nxt = S_DRAIN;
          else dr_nxt = dr_r + 2'd1;
        end else begin
          dc_nxt = dc_r + 2'd1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_POP;
      end
      S_DONE: begin
        if (!out_busy) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    dr_r        <= dr_nxt;
    dc_r        <= dc_nxt;
    len_r       <= len_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_col_r  <= pend_col_nxt;
  end

endmodule

`default_nettype wire
